// ===== rtl/core/rti_pkg.sv =====
// shared types, register indexes and width helpers for the ray/triangle intersector
// no dependencies; imported by every module of the block
`default_nettype none

package rti_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_VERTEX_A = 2'd0;
    localparam t_cfg_idx REG_VERTEX_B = 2'd1;
    localparam t_cfg_idx REG_VERTEX_C = 2'd2;

    // fraction bits of the ray parameter
    localparam int FRAC_BITS = 16;

    // per-item control travelling with the data
    typedef struct packed {
        logic valid;
        logic miss;
    } t_ctl;

    // width of the determinant and numerator sums
    function automatic int sum_w(input int cw);
        return 3 * cw + 7;
    endfunction

    // width of the normalised determinant (never negative)
    function automatic int det_w(input int cw);
        return sum_w(cw) - 1;
    endfunction

    // width of the offset dividend fed to the divider
    function automatic int num_w(input int cw, input int tw);
        return sum_w(cw) + tw + 17;
    endfunction

    // width of the ray side data: origin, direction and t interval
    function automatic int side_w(input int cw, input int tw);
        return 6 * cw + 2 * tw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
// ray/triangle intersection by Cramer's rule, results on the o_valid strobe;
// one ray accepted every cycle, busy never asserted.
// the pipeline is the T_WIDTH+1 stage restoring divider for t, behind an
// 8 stage determinant front end and a 2 stage hit point back end.
// synchronous reset clears the pipeline valids and the three vertex registers;
// results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none

module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 21,
    parameter int T_WIDTH     = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire  signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire  signed [COORD_WIDTH-1:0] i_origin_z,
    input  wire  signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire  signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire  signed [COORD_WIDTH-1:0] i_dir_z,
    input  wire  signed [T_WIDTH-1:0]     i_t_lower,
    input  wire  signed [T_WIDTH-1:0]     i_t_upper,
    input  wire                          i_cfg_we,
    input  wire  t_cfg_idx               i_cfg_idx,
    input  wire  [3*COORD_WIDTH-1:0]      i_cfg_data,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [T_WIDTH-1:0]     o_hit_t,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z
);

    localparam int NUMW    = num_w(COORD_WIDTH, T_WIDTH);
    localparam int DETW    = det_w(COORD_WIDTH);
    localparam int SIDEW   = side_w(COORD_WIDTH, T_WIDTH);
    localparam int QW      = T_WIDTH + 1;
    localparam int LATENCY = T_WIDTH + 11;

    logic [3*COORD_WIDTH-1:0] r_vtx_a, r_vtx_b, r_vtx_c;
    logic [SIDEW-1:0]         side_in;

    t_ctl             w_ctl  [QW+1];
    logic [NUMW-1:0]  w_num  [QW+1];
    logic [DETW-1:0]  w_det  [QW+1];
    logic [QW-1:0]    w_quo  [QW+1];
    logic [SIDEW-1:0] w_side [QW+1];

    // the pipeline takes a ray every cycle
    assign busy = 1'b0;

    // vertex registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= '0;
            r_vtx_b <= '0;
            r_vtx_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VERTEX_A: r_vtx_a <= i_cfg_data;
                REG_VERTEX_B: r_vtx_b <= i_cfg_data;
                REG_VERTEX_C: r_vtx_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ray side data: origin, direction, t interval
    assign side_in = {i_t_upper, i_t_lower, i_dir_z, i_dir_y, i_dir_x,
                      i_origin_z, i_origin_y, i_origin_x};

    // determinant front end
    rti_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_WIDTH     (T_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_vtx_a (r_vtx_a),
        .i_vtx_b (r_vtx_b),
        .i_vtx_c (r_vtx_c),
        .i_side  (side_in),
        .o_ctl   (w_ctl[0]),
        .o_num   (w_num[0]),
        .o_det   (w_det[0]),
        .o_side  (w_side[0])
    );

    assign w_quo[0] = '0;

    // divider chain, most significant quotient bit first
    for (genvar s = 0; s < QW; s++) begin : g_div
        rti_div_stage #(
            .NUMW  (NUMW),
            .DETW  (DETW),
            .SIDEW (SIDEW),
            .QW    (QW),
            .SHIFT (T_WIDTH - s),
            .CHECK (s == 0)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[s]),
            .i_num   (w_num[s]),
            .i_det   (w_det[s]),
            .i_quo   (w_quo[s]),
            .i_side  (w_side[s]),
            .o_ctl   (w_ctl[s+1]),
            .o_num   (w_num[s+1]),
            .o_det   (w_det[s+1]),
            .o_quo   (w_quo[s+1]),
            .o_side  (w_side[s+1])
        );
    end

    // interval test and hit point; the final remainder marks an inexact t
    rti_point #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_WIDTH     (T_WIDTH)
    ) u_point (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl[QW]),
        .i_quo     (w_quo[QW][T_WIDTH-1:0]),
        .i_rem_nz  (|w_num[QW]),
        .i_side    (w_side[QW]),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_hit_t   (o_hit_t),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

    // every accepted ray gives exactly one result transfer after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result strobe missing after accepted ray");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without accepted ray");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid)
        else $error("hit flag outside a result transfer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_t == '0 && o_point_x == '0 &&
                                 o_point_y == '0 && o_point_z == '0))
        else $error("miss result carries non-zero payload");

endmodule

`default_nettype wire

// ===== rtl/core/rti_front.sv =====
// front end: edge vectors, cross products, Cramer determinants and hit tests on sign and range
// depends on rti_pkg; feeds the divider chain with dividend, divisor, control and side data
`default_nettype none

module rti_front
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 21,
    parameter int T_WIDTH     = 32
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_valid,
    input  wire  [3*COORD_WIDTH-1:0]                i_vtx_a,
    input  wire  [3*COORD_WIDTH-1:0]                i_vtx_b,
    input  wire  [3*COORD_WIDTH-1:0]                i_vtx_c,
    input  wire  [side_w(COORD_WIDTH, T_WIDTH)-1:0] i_side,
    output t_ctl                                    o_ctl,
    output logic [num_w(COORD_WIDTH, T_WIDTH)-1:0]  o_num,
    output logic [det_w(COORD_WIDTH)-1:0]           o_det,
    output logic [side_w(COORD_WIDTH, T_WIDTH)-1:0] o_side
);

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int NW    = 2 * CW + 3;
    localparam int LB    = CW + 2;
    localparam int HB    = NW - LB;
    localparam int SW    = sum_w(CW);
    localparam int DETW  = det_w(CW);
    localparam int NUMW  = num_w(CW, T_WIDTH);
    localparam int SIDEW = side_w(CW, T_WIDTH);
    localparam int NSTG  = 8;

    // operand order: a,b,c (0..2), d,e,f (3..5), j,k,l (6..8), g,h,i (9..11)
    localparam int PL [12] = '{4, 10, 9, 3, 3, 4, 0, 6, 6, 0, 1, 7};
    localparam int PR [12] = '{11, 5, 5, 11, 10, 9, 7, 1, 2, 8, 8, 2};
    // second-level products: det, t, gamma, beta numerators, three terms each
    localparam int XSEL [12] = '{0, 1, 2, 5, 4, 3, 11, 10, 9, 6, 7, 8};
    localparam int YSEL [12] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 0, 1, 2};

    logic signed [CW-1:0]   va [3];
    logic signed [CW-1:0]   vb [3];
    logic signed [CW-1:0]   vc [3];
    logic signed [CW-1:0]   org [3];
    logic signed [CW-1:0]   dir [3];

    logic                   r_vld [NSTG];
    logic [SIDEW-1:0]       r_side [NSTG];
    logic signed [EW-1:0]   r_op1 [12];
    logic signed [EW-1:0]   r_op2 [12];
    logic signed [EW-1:0]   r_op3 [12];
    logic signed [PW-1:0]   r_pr [12];
    logic signed [NW-1:0]   r_mn [6];
    logic signed [EW+HB-1:0] r_ph [12];
    logic signed [EW+LB:0]  r_pl [12];
    logic signed [SW-1:0]   r_p [12];
    logic signed [SW-1:0]   r_det6, r_tn6, r_gn6, r_bn6;
    logic signed [SW-1:0]   r_det7, r_tn7, r_gn7, r_bn7;
    logic                   r_miss7, r_miss8;
    logic [NUMW-1:0]        r_num;
    logic [DETW-1:0]        r_dtr;

    logic signed [NUMW-1:0] n_num;
    logic                   gmiss, bmiss;

    // unpack vertices and ray
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            va[n]  = i_vtx_a[n*CW +: CW];
            vb[n]  = i_vtx_b[n*CW +: CW];
            vc[n]  = i_vtx_c[n*CW +: CW];
            org[n] = i_side[n*CW +: CW];
            dir[n] = i_side[(3+n)*CW +: CW];
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NSTG; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // side data delay line
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int s = 1; s < NSTG; s++) r_side[s] <= r_side[s-1];
    end

    // stage 1: edge and offset vectors
    always_ff @(posedge i_clk) begin
        for (int n = 0; n < 3; n++) begin
            r_op1[n]   <= $signed({va[n][CW-1], va[n]}) - $signed({vb[n][CW-1], vb[n]});
            r_op1[3+n] <= $signed({va[n][CW-1], va[n]}) - $signed({vc[n][CW-1], vc[n]});
            r_op1[6+n] <= $signed({va[n][CW-1], va[n]}) - $signed({org[n][CW-1], org[n]});
            r_op1[9+n] <= $signed({dir[n][CW-1], dir[n]});
        end
    end

    // stage 2: first-level products, operands carried on
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 12; k++) begin
            r_pr[k]  <= r_op1[PL[k]] * r_op1[PR[k]];
            r_op2[k] <= r_op1[k];
        end
    end

    // stage 3: 2x2 minors
    always_ff @(posedge i_clk) begin
        for (int q = 0; q < 6; q++) begin
            r_mn[q] <= $signed({r_pr[2*q][PW-1], r_pr[2*q]})
                     - $signed({r_pr[2*q+1][PW-1], r_pr[2*q+1]});
        end
        for (int k = 0; k < 12; k++) r_op3[k] <= r_op2[k];
    end

    // stage 4: partial products, minor split into high and low halves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 12; k++) begin
            r_ph[k] <= r_op3[XSEL[k]] * $signed(r_mn[YSEL[k]][NW-1:LB]);
            r_pl[k] <= r_op3[XSEL[k]] * $signed({1'b0, r_mn[YSEL[k]][LB-1:0]});
        end
    end

    // stage 5: recombine partial products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 12; k++) begin
            r_p[k] <= (SW'(r_ph[k]) <<< LB) + SW'(r_pl[k]);
        end
    end

    // stage 6: determinant and numerators
    always_ff @(posedge i_clk) begin
        r_det6 <= r_p[0] + r_p[1] + r_p[2];
        r_tn6  <= -(r_p[3] + r_p[4] + r_p[5]);
        r_gn6  <= r_p[6] + r_p[7] + r_p[8];
        r_bn6  <= r_p[9] + r_p[10] + r_p[11];
    end

    // stage 7: make the determinant positive, flag a singular system
    always_ff @(posedge i_clk) begin
        if (r_det6[SW-1]) begin
            r_det7 <= -r_det6;
            r_tn7  <= -r_tn6;
            r_gn7  <= -r_gn6;
            r_bn7  <= -r_bn6;
        end else begin
            r_det7 <= r_det6;
            r_tn7  <= r_tn6;
            r_gn7  <= r_gn6;
            r_bn7  <= r_bn6;
        end
        r_miss7 <= (r_det6 == '0);
    end

    // barycentric tests and offset dividend
    always_comb begin
        gmiss = r_gn7[SW-1] || (r_gn7 > r_det7);
        bmiss = r_bn7[SW-1] || (r_bn7 > (r_det7 - r_gn7));
        n_num = (NUMW'(r_tn7) <<< FRAC_BITS) + (NUMW'(r_det7) <<< (T_WIDTH - 1));
    end

    // stage 8
    always_ff @(posedge i_clk) begin
        r_miss8 <= r_miss7 || gmiss || bmiss || n_num[NUMW-1];
        r_num   <= n_num;
        r_dtr   <= r_det7[DETW-1:0];
    end

    assign o_ctl  = '{valid: r_vld[NSTG-1], miss: r_miss8};
    assign o_num  = r_num;
    assign o_det  = r_dtr;
    assign o_side = r_side[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/core/rti_div_stage.sv =====
// one stage of the restoring divider: one quotient bit per stage
// depends on rti_pkg for the control struct
`default_nettype none

module rti_div_stage
    import rti_pkg::*;
#(
    parameter int NUMW  = 119,
    parameter int DETW  = 69,
    parameter int SIDEW = 190,
    parameter int QW    = 33,
    parameter int SHIFT = 0,
    parameter bit CHECK = 1'b0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  t_ctl       i_ctl,
    input  wire  [NUMW-1:0]  i_num,
    input  wire  [DETW-1:0]  i_det,
    input  wire  [QW-1:0]    i_quo,
    input  wire  [SIDEW-1:0] i_side,
    output t_ctl             o_ctl,
    output logic [NUMW-1:0]  o_num,
    output logic [DETW-1:0]  o_det,
    output logic [QW-1:0]    o_quo,
    output logic [SIDEW-1:0] o_side
);

    logic [NUMW-1:0] dk;
    logic            take;

    // trial subtract of the shifted divisor
    always_comb begin
        dk   = NUMW'(i_det) << SHIFT;
        take = (i_num >= dk);
    end

    // control: the top stage flags a quotient out of range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
            o_ctl.miss  <= i_ctl.miss || (CHECK && take);
        end
    end

    // remainder, quotient and side data
    always_ff @(posedge i_clk) begin
        o_num  <= take ? (i_num - dk) : i_num;
        o_det  <= i_det;
        o_quo  <= {i_quo[QW-2:0], take};
        o_side <= i_side;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rti_point.sv =====
// back end: interval test on t, hit point by multiply, shift and saturation
// depends on rti_pkg; drives the result ports
`default_nettype none

module rti_point
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 21,
    parameter int T_WIDTH     = 32
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire  t_ctl                              i_ctl,
    input  wire  [T_WIDTH-1:0]                      i_quo,
    input  wire                                     i_rem_nz,
    input  wire  [side_w(COORD_WIDTH, T_WIDTH)-1:0] i_side,
    output logic                                    o_valid,
    output logic                                    o_hit,
    output logic signed [T_WIDTH-1:0]               o_hit_t,
    output logic signed [COORD_WIDTH-1:0]           o_point_x,
    output logic signed [COORD_WIDTH-1:0]           o_point_y,
    output logic signed [COORD_WIDTH-1:0]           o_point_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = T_WIDTH + CW;
    localparam int SPW  = MW - FRAC_BITS;
    localparam int SUMW = SPW + 1;
    localparam logic signed [SUMW-1:0] MAXV = SUMW'((1 << (CW - 1)) - 1);
    localparam logic signed [SUMW-1:0] MINV = SUMW'(-(1 << (CW - 1)));

    logic signed [T_WIDTH-1:0] tq, tl, tu;
    logic signed [CW-1:0]      org [3];
    logic signed [CW-1:0]      dir [3];
    logic                      n_hit;

    logic                      r_v, r_hit;
    logic signed [T_WIDTH-1:0] r_tq;
    logic signed [MW-1:0]      r_prod [3];
    logic signed [CW-1:0]      r_org [3];

    logic signed [SUMW-1:0]    sum [3];
    logic signed [CW-1:0]      sat [3];

    // undo the divider offset and test the interval
    // at the upper bound the floored t only counts when the division is exact
    always_comb begin
        tq = {~i_quo[T_WIDTH-1], i_quo[T_WIDTH-2:0]};
        tl = i_side[6*CW +: T_WIDTH];
        tu = i_side[6*CW+T_WIDTH +: T_WIDTH];
        for (int n = 0; n < 3; n++) begin
            org[n] = i_side[n*CW +: CW];
            dir[n] = i_side[(3+n)*CW +: CW];
        end
        n_hit = i_ctl.valid && !i_ctl.miss && (tq >= tl)
             && ((tq < tu) || ((tq == tu) && !i_rem_nz));
    end

    // stage 1: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v   <= i_ctl.valid;
            r_hit <= n_hit;
        end
    end

    // stage 1: t times direction
    always_ff @(posedge i_clk) begin
        r_tq <= tq;
        for (int n = 0; n < 3; n++) begin
            r_prod[n] <= tq * dir[n];
            r_org[n]  <= org[n];
        end
    end

    // add to origin and saturate
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            sum[n] = $signed({r_prod[n][MW-1], r_prod[n][MW-1:FRAC_BITS]}) + SUMW'(r_org[n]);
            if (sum[n] > MAXV) begin
                sat[n] = MAXV[CW-1:0];
            end else if (sum[n] < MINV) begin
                sat[n] = MINV[CW-1:0];
            end else begin
                sat[n] = sum[n][CW-1:0];
            end
        end
    end

    // stage 2: result transfer, zeroed on a miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_hit   <= 1'b0;
        end else begin
            o_valid <= r_v;
            o_hit   <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit_t   <= r_hit ? r_tq : '0;
        o_point_x <= r_hit ? sat[0] : '0;
        o_point_y <= r_hit ? sat[1] : '0;
        o_point_z <= r_hit ? sat[2] : '0;
    end

endmodule

`default_nettype wire

// ===== sim/ray_triangle_intersect_tb.sv =====
// self-checking testbench for ray_triangle_intersect: aimed and random rays,
// several triangles, random start gaps; depends on rti_pkg and the block rtl
`timescale 1ns / 100ps

module ray_triangle_intersect_tb;
    import rti_pkg::*;

    localparam int CW      = 21;
    localparam int TW      = 32;
    localparam int LATENCY = TW + 11;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (CW - 1));

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [TW-1:0] t_param;
    typedef logic signed [255:0]  t_wide;

    typedef struct {
        t_coord ox, oy, oz, dx, dy, dz;
        t_param tl, tu;
    } t_ray;

    typedef struct {
        logic   hit;
        t_param t;
        t_coord px, py, pz;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_coord i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    t_coord i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    t_param i_t_lower = '0, i_t_upper = '0;
    logic i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_idx = REG_VERTEX_A;
    logic [3*CW-1:0] i_cfg_data = '0;
    logic o_valid, o_hit;
    t_param o_hit_t;
    t_coord o_point_x, o_point_y, o_point_z;

    ray_triangle_intersect #(.COORD_WIDTH(CW), .T_WIDTH(TW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_t_lower(i_t_lower), .i_t_upper(i_t_upper),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_hit(o_hit), .o_hit_t(o_hit_t),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_z(o_point_z)
    );

    // triangle copy used by the predictor
    logic [3*CW-1:0] tri_vtx [3] = '{default: '0};

    t_ray ray_q [$];
    t_hit hit_q [$];
    int n_queued = 0, n_checked = 0, n_hits = 0, n_errors = 0;
    int n_tris = 0;
    bit no_idle = 1'b0;

    initial forever #6 i_clk = ~i_clk;

    // --------------------------------------------------------------
    // predictor helpers
    function automatic t_wide vcoord(input logic [3*CW-1:0] v, input int n);
        t_coord c;
        c = v[n*CW +: CW];
        return t_wide'(c);
    endfunction

    function automatic t_coord sat_coord(input t_wide v);
        if (v > t_wide'(CMAX)) return t_coord'(CMAX);
        if (v < t_wide'(CMIN)) return t_coord'(CMIN);
        return t_coord'(v);
    endfunction

    // exact Cramer's rule intersection in wide signed integers
    function automatic t_hit intersect_ray(input t_ray r);
        t_wide a, b, c, d, e, f, g, h, i, j, k, l;
        t_wide m1, m2, m3, n1, n2, n3, det, tnum, gnum, bnum, tq16, tq, tl, tu;
        t_hit res;
        res = '{hit: 1'b0, t: '0, px: '0, py: '0, pz: '0};
        a = vcoord(tri_vtx[0], 0) - vcoord(tri_vtx[1], 0);
        b = vcoord(tri_vtx[0], 1) - vcoord(tri_vtx[1], 1);
        c = vcoord(tri_vtx[0], 2) - vcoord(tri_vtx[1], 2);
        d = vcoord(tri_vtx[0], 0) - vcoord(tri_vtx[2], 0);
        e = vcoord(tri_vtx[0], 1) - vcoord(tri_vtx[2], 1);
        f = vcoord(tri_vtx[0], 2) - vcoord(tri_vtx[2], 2);
        g = t_wide'(r.dx); h = t_wide'(r.dy); i = t_wide'(r.dz);
        j = vcoord(tri_vtx[0], 0) - t_wide'(r.ox);
        k = vcoord(tri_vtx[0], 1) - t_wide'(r.oy);
        l = vcoord(tri_vtx[0], 2) - t_wide'(r.oz);
        tl = t_wide'(r.tl); tu = t_wide'(r.tu);
        m1 = e*i - h*f; m2 = g*f - d*i; m3 = d*h - e*g;
        n1 = a*k - j*b; n2 = j*c - a*l; n3 = b*l - k*c;
        det  = a*m1 + b*m2 + c*m3;
        tnum = -(f*n1 + e*n2 + d*n3);
        gnum = i*n1 + h*n2 + g*n3;
        bnum = j*m1 + k*m2 + l*m3;
        // zero determinant: degenerate triangle or parallel ray
        if (det == 0) return res;
        if (det < 0) begin
            det = -det; tnum = -tnum; gnum = -gnum; bnum = -bnum;
        end
        tq16 = tnum <<< 16;
        if (tq16 < tl*det || tq16 > tu*det) return res;
        if (gnum < 0 || gnum > det) return res;
        if (bnum < 0 || bnum > det - gnum) return res;
        // floor division
        tq = tq16 / det;
        if (tq16 < 0 && tq*det != tq16) tq = tq - 1;
        res.hit = 1'b1;
        res.t   = t_param'(tq);
        res.px  = sat_coord(t_wide'(r.ox) + ((tq * g) >>> 16));
        res.py  = sat_coord(t_wide'(r.oy) + ((tq * h) >>> 16));
        res.pz  = sat_coord(t_wide'(r.oz) + ((tq * i) >>> 16));
        return res;
    endfunction

    // --------------------------------------------------------------
    // stimulus helpers
    function automatic t_coord clamp_coord(input longint v);
        if (v > CMAX) return t_coord'(CMAX);
        if (v < CMIN) return t_coord'(CMIN);
        return t_coord'(v);
    endfunction

    function automatic t_coord rand_coord(input int span);
        return clamp_coord(longint'($urandom_range(0, 2*span)) - span);
    endfunction

    function automatic logic [3*CW-1:0] pack_vertex(input t_coord x, y, z);
        return {z, y, x};
    endfunction

    function automatic t_ray noise_ray();
        t_ray r;
        r.ox = t_coord'($urandom); r.oy = t_coord'($urandom); r.oz = t_coord'($urandom);
        r.dx = t_coord'($urandom); r.dy = t_coord'($urandom); r.dz = t_coord'($urandom);
        r.tl = t_param'($urandom); r.tu = t_param'($urandom);
        return r;
    endfunction

    // ray through a random point of the triangle, t near a power of two from one to sixteen
    function automatic t_ray aimed_ray();
        t_ray r;
        longint pt [3], o;
        int bw, gw, off, sc;
        bw = $urandom_range(0, 256);
        gw = $urandom_range(0, 256 - bw);
        off = 1 << $urandom_range(4, 18);
        sc = $urandom_range(0, 4);
        for (int n = 0; n < 3; n++) begin
            longint va, vb, vc;
            va = vcoord(tri_vtx[0], n); vb = vcoord(tri_vtx[1], n);
            vc = vcoord(tri_vtx[2], n);
            pt[n] = va + ((vb - va) * bw) / 256 + ((vc - va) * gw) / 256;
        end
        o = pt[0] + $urandom_range(0, 2*off) - off; r.ox = clamp_coord(o);
        o = pt[1] + $urandom_range(0, 2*off) - off; r.oy = clamp_coord(o);
        o = pt[2] + $urandom_range(0, 2*off) - off; r.oz = clamp_coord(o);
        // shorter direction means larger t
        r.dx = clamp_coord((pt[0] - r.ox) >>> sc);
        r.dy = clamp_coord((pt[1] - r.oy) >>> sc);
        r.dz = clamp_coord((pt[2] - r.oz) >>> sc);
        r.tl = t_param'($urandom_range(0, 65536));
        r.tu = t_param'((65536 << sc) + $urandom_range(0, 65536));
        case ($urandom_range(0, 9))
            0: begin r.tl = r.tu + 1; r.tu = t_param'(0); end
            1: begin r.tl = {1'b1, {(TW-1){1'b0}}}; r.tu = {1'b0, {(TW-1){1'b1}}}; end
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_ray(input t_ray r);
        ray_q.push_back(r);
        n_queued++;
    endtask

    task automatic wait_drained();
        wait (n_checked == n_queued);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic load_triangle(input logic [3*CW-1:0] va, vb, vc);
        t_cfg_idx idx [3];
        logic [3*CW-1:0] v [3];
        idx = '{REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C};
        v = '{va, vb, vc};
        for (int n = 0; n < 3; n++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[n];
            i_cfg_data <= v[n];
            tri_vtx[n] = v[n];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_tris++;
    endtask

    task automatic run_rays(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 7) push_ray(aimed_ray());
            else push_ray(noise_ray());
        end
        wait_drained();
    endtask

    // --------------------------------------------------------------
    // driver: one ray per transfer, random gaps between rays
    t_ray cur_ray;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) hit_q.push_back(intersect_ray(cur_ray));
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (ray_q.size() > 0) begin
                    cur_ray = ray_q.pop_front();
                    i_origin_x <= cur_ray.ox; i_origin_y <= cur_ray.oy;
                    i_origin_z <= cur_ray.oz;
                    i_dir_x <= cur_ray.dx; i_dir_y <= cur_ray.dy; i_dir_z <= cur_ray.dz;
                    i_t_lower <= cur_ray.tl; i_t_upper <= cur_ray.tu;
                    start <= 1'b1;
                    // mostly back to back, some short gaps, a few long ones
                    if (no_idle || $urandom_range(0, 9) < 6) gap_left = 0;
                    else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 3);
                    else gap_left = $urandom_range(10, 60);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result strobe with the oldest prediction
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && o_valid) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0b t=%0d", $time, o_hit, o_hit_t);
                n_errors++;
            end else begin
                want = hit_q.pop_front();
                if (o_hit !== want.hit || o_hit_t !== want.t || o_point_x !== want.px
                    || o_point_y !== want.py || o_point_z !== want.pz) begin
                    $display("%0t: mismatch expected hit=%0b t=%0d p=(%0d,%0d,%0d)",
                             $time, want.hit, want.t, want.px, want.py, want.pz);
                    $display("%0t:          actual   hit=%0b t=%0d p=(%0d,%0d,%0d)",
                             $time, o_hit, o_hit_t, o_point_x, o_point_y, o_point_z);
                    n_errors++;
                end
                if (want.hit) n_hits++;
            end
            n_checked++;
        end
    end

    // --------------------------------------------------------------
    // phases of the run
    initial begin
        t_ray r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset triangle is degenerate: everything misses
        r = noise_ray();
        push_ray(r);
        wait_drained();

        // directed set on a small triangle in the z = 0 plane
        load_triangle(pack_vertex(-2048, -2048, 0), pack_vertex(4096, -2048, 0),
                      pack_vertex(-2048, 4096, 0));
        r = '{ox: 0, oy: 0, oz: 1024, dx: 0, dy: 0, dz: -1024, tl: 0, tu: 65536};
        push_ray(r);                                       // plain hit at t = 1
        r.tl = 65537; push_ray(r);                          // t below interval
        r.tl = 0; r.tu = 65535; push_ray(r);                // t above interval
        r.tl = 70000; r.tu = 60000; push_ray(r);            // empty interval
        r.tl = 0; r.tu = 65536; r.dz = 0; r.dx = 1024; push_ray(r);  // parallel ray
        r.dx = 0; r.dz = -1024; r.ox = -2048; r.oy = -2048; push_ray(r);  // on vertex a
        r.ox = 4096; push_ray(r);                           // on vertex b
        r.ox = 1024; r.oy = 1024; push_ray(r);              // on edge b-c
        r.ox = 1025; push_ray(r);                           // just outside edge b-c
        r.ox = -2049; r.oy = 0; push_ray(r);                // just outside edge a-c
        r.ox = 0; r.oz = -1024; push_ray(r);                // hit behind the origin
        r.tl = {1'b1, {(TW-1){1'b0}}}; push_ray(r);
        r.dz = 1; r.oz = -1; r.tu = {1'b0, {(TW-1){1'b1}}}; push_ray(r);
        r = '{ox: CMAX, oy: CMAX, oz: CMAX, dx: CMIN, dy: CMIN, dz: CMIN,
              tl: {1'b1, {(TW-1){1'b0}}}, tu: {1'b0, {(TW-1){1'b1}}}};
        push_ray(r);
        r = '{ox: CMIN, oy: CMIN, oz: CMIN, dx: CMAX, dy: CMAX, dz: CMAX,
              tl: {1'b1, {(TW-1){1'b0}}}, tu: {1'b0, {(TW-1){1'b1}}}};
        push_ray(r);
        r = '{ox: 0, oy: 0, oz: 1, dx: 1, dy: 1, dz: -1, tl: 0, tu: 65536};
        push_ray(r);
        wait_drained();

        // random content on the small triangle, then back to back with no gaps
        run_rays(300);
        no_idle = 1'b1;
        run_rays(200);
        no_idle = 1'b0;

        // extreme corners of the coordinate range
        load_triangle(pack_vertex(CMIN, CMIN, CMIN), pack_vertex(CMAX, CMIN, CMAX),
                      pack_vertex(CMIN, CMAX, CMAX));
        run_rays(300);
        load_triangle(pack_vertex(CMAX, CMAX, CMAX), pack_vertex(CMIN, CMAX, CMIN),
                      pack_vertex(CMAX, CMIN, CMIN));
        run_rays(200);

        // random triangles of mixed size, sometimes degenerate
        for (int n = 0; n < 8; n++) begin
            int span;
            span = 1 << $urandom_range(6, 20);
            if (n == 3)
                load_triangle(pack_vertex(100, 200, 300), pack_vertex(200, 400, 600),
                              pack_vertex(300, 600, 900));
            else
                load_triangle({rand_coord(span), rand_coord(span), rand_coord(span)},
                              {rand_coord(span), rand_coord(span), rand_coord(span)},
                              {rand_coord(span), rand_coord(span), rand_coord(span)});
            run_rays(100);
        end

        $display("rays checked: %0d, hits: %0d, triangles loaded: %0d",
                 n_checked, n_hits, n_tris);
        if (n_errors == 0 && hit_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout after %0d of %0d rays", n_checked, n_queued);
        $display("FAILURE");
        $finish;
    end

endmodule
